// ===== src/ip_prefix_ignore_list_match_macros.svh =====
// Assertion macros used by the ignore list match controller.
`ifndef IP_PREFIX_IGNORE_LIST_MATCH_MACROS_SVH
`define IP_PREFIX_IGNORE_LIST_MATCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IPIL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipil assertion failed");

// Next-cycle implication, disabled during reset.
`define IPIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipil assertion failed");

`endif

// ===== src/ipil_pkg.sv =====
// Package: types, constants and mask functions of the prefix ignore list matcher.
package ipil_pkg;

    localparam int MAX_ENTRIES_DEF = 32;
    localparam int ADDR_W          = 64;
    localparam int V4_W            = 32;
    localparam int CMD_W           = 2;
    localparam int STATUS_W        = 3;
    localparam int PLEN_W          = 8;
    localparam int V4_PREFIX_MAX   = 32;
    localparam int V6_PREFIX_MAX   = 128;
    localparam int V4_PLEN_W       = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_INSERT   = 2'd1,
        CMD_FINALIZE = 2'd2,
        CMD_LOOKUP   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_ABSENT    = 3'd0,
        STS_PRESENT   = 3'd1,
        STS_NOT_READY = 3'd2,
        STS_DONE      = 3'd3,
        STS_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    typedef struct packed {
        logic              valid;
        logic              family;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic              hit;
    } token_t;

    typedef struct packed {
        logic              en;
        logic              family;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [ADDR_W-1:0] mask_high;
        logic [ADDR_W-1:0] mask_low;
    } entry_wr_t;

    function automatic logic [2*ADDR_W-1:0] v6_mask(logic has_p, logic [PLEN_W-1:0] plen);
        logic [PLEN_W-1:0] p;
        p = !has_p ? PLEN_W'(V6_PREFIX_MAX)
            : ((plen > PLEN_W'(V6_PREFIX_MAX)) ? PLEN_W'(V6_PREFIX_MAX) : plen);
        return ~({(2*ADDR_W){1'b1}} >> p);
    endfunction

    function automatic logic [V4_W-1:0] v4_mask(logic has_p, logic [PLEN_W-1:0] plen);
        logic [V4_PLEN_W-1:0] p;
        p = !has_p ? V4_PLEN_W'(V4_PREFIX_MAX)
            : ((plen > PLEN_W'(V4_PREFIX_MAX)) ? V4_PLEN_W'(V4_PREFIX_MAX)
               : plen[V4_PLEN_W-1:0]);
        return ~({V4_W{1'b1}} >> p);
    endfunction

endpackage

// ===== src/ipil_cell.sv =====
// One table cell: holds one entry and matches the passing lookup token.
module ipil_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               we,
    input  ipil_pkg::entry_wr_t wr,
    input  ipil_pkg::token_t   tok_in,
    output ipil_pkg::token_t   tok_out
);
    import ipil_pkg::*;

    logic              family_reg;
    logic [ADDR_W-1:0] addr_high_reg;
    logic [ADDR_W-1:0] addr_low_reg;
    logic [ADDR_W-1:0] mask_high_reg;
    logic [ADDR_W-1:0] mask_low_reg;
    token_t            tok_reg;
    token_t            tok_next;
    logic              match;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            family_reg    <= wr.family;
            addr_high_reg <= wr.addr_high;
            addr_low_reg  <= wr.addr_low;
            mask_high_reg <= wr.mask_high;
            mask_low_reg  <= wr.mask_low;
        end
    end

    always_comb
    begin
        match = en && (family_reg == tok_in.family)
                && ((tok_in.addr_high & mask_high_reg) == addr_high_reg)
                && ((tok_in.addr_low & mask_low_reg) == addr_low_reg);
        tok_next     = tok_in;
        tok_next.hit = tok_in.hit | match;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== src/ipil_ctrl.sv =====
// Command controller: entry count, ready flag, token injection and result register.
module ipil_ctrl #(
    parameter int MAX_ENTRIES = ipil_pkg::MAX_ENTRIES_DEF,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ipil_pkg::CMD_W-1:0]    command,
    input  logic                          family,
    input  logic [ipil_pkg::ADDR_W-1:0]   address_high,
    input  logic [ipil_pkg::ADDR_W-1:0]   address_low,
    input  logic                          has_prefix,
    input  logic [ipil_pkg::PLEN_W-1:0]   prefix_length,
    input  ipil_pkg::token_t              tail,
    output ipil_pkg::token_t              inject,
    output ipil_pkg::entry_wr_t           wr,
    output logic [CNT_W-1:0]              count,
    output logic                          strobe,
    output logic [ipil_pkg::STATUS_W-1:0] status
);
    import ipil_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ready_reg, ready_next;
    logic                  strobe_reg, strobe_next;
    status_t               status_reg, status_next;
    logic [2*ADDR_W-1:0]   mask6;
    logic [V4_W-1:0]       mask4;

    assign mask6 = v6_mask(has_prefix, prefix_length);
    assign mask4 = v4_mask(has_prefix, prefix_length);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ready_reg  <= 1'b0;
            strobe_reg <= 1'b0;
            status_reg <= STS_ABSENT;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ready_reg  <= ready_next;
            strobe_reg <= strobe_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ready_next       = ready_reg;
        strobe_next      = 1'b0;
        status_next      = status_reg;
        inject.valid     = 1'b0;
        inject.family    = family;
        inject.addr_high = address_high;
        inject.addr_low  = address_low;
        inject.hit       = 1'b0;
        wr.en            = 1'b0;
        wr.family        = family;
        if (family)
        begin
            wr.addr_high = address_high;
            wr.addr_low  = address_low;
            wr.mask_high = mask6[2*ADDR_W-1:ADDR_W];
            wr.mask_low  = mask6[ADDR_W-1:0];
        end
        else
        begin
            wr.addr_high = '0;
            wr.addr_low  = {{(ADDR_W-V4_W){1'b0}}, address_low[V4_W-1:0]};
            wr.mask_high = '0;
            wr.mask_low  = {{(ADDR_W-V4_W){1'b0}}, mask4};
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    strobe_next = 1'b1;
                    status_next = STS_DONE;
                    case (cmd_t'(command))
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            ready_next = 1'b0;
                        end
                        CMD_INSERT:
                        begin
                            if (count_reg == CNT_W'(MAX_ENTRIES))
                            begin
                                status_next = STS_FULL;
                            end
                            else
                            begin
                                wr.en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_FINALIZE:
                        begin
                            ready_next = 1'b1;
                        end
                        CMD_LOOKUP:
                        begin
                            if (!ready_reg)
                            begin
                                status_next = STS_NOT_READY;
                            end
                            else
                            begin
                                strobe_next  = 1'b0;
                                status_next  = status_reg;
                                inject.valid = 1'b1;
                                state_next   = ST_WALK;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b0;
                            status_next = status_reg;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (tail.valid)
                begin
                    strobe_next = 1'b1;
                    status_next = tail.hit ? STS_PRESENT : STS_ABSENT;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign count  = count_reg;
    assign strobe = strobe_reg;
    assign status = status_reg;

    `include "ip_prefix_ignore_list_match_macros.svh"

    `IPIL_ASSERT_NOW(a_walk_no_strobe, clk, rst_n, state_reg == ST_WALK, !strobe_reg)
    `IPIL_ASSERT_NOW(a_tail_in_walk, clk, rst_n, tail.valid, state_reg == ST_WALK)
    `IPIL_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_ENTRIES))
    `IPIL_ASSERT_NEXT(a_not_ready, clk, rst_n, start && !busy && command == CMD_LOOKUP && !ready_reg, strobe_reg && status_reg == STS_NOT_READY)

endmodule

// ===== src/ip_prefix_ignore_list_match.sv =====
// Top level: prefix ignore list matcher built as a chain of entry cells.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+----------------------------------------------
//  command   | start, busy           | command, family, address_high, address_low,
//            |                       | has_prefix, prefix_length
//  result    | strobe                | status
//
// Clear, insert, finalize and lookup before finalize: result strobes one cycle after
// acceptance; busy stays low.
// Lookup on a finalized table: the key walks the cell chain one cell per cycle through each cell's
// token register, then the result register strobes; busy is high until the strobe.
// Reset clears the entry count, the ready flag and the chain tokens; entries need no clearing.
// The result is shown for one cycle and cannot be held off.
module ip_prefix_ignore_list_match #(
    parameter int MAX_ENTRIES = ipil_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ipil_pkg::CMD_W-1:0]    command,
    input  logic                          family,
    input  logic [ipil_pkg::ADDR_W-1:0]   address_high,
    input  logic [ipil_pkg::ADDR_W-1:0]   address_low,
    input  logic                          has_prefix,
    input  logic [ipil_pkg::PLEN_W-1:0]   prefix_length,
    output logic                          strobe,
    output logic [ipil_pkg::STATUS_W-1:0] status
);
    import ipil_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    token_t           chain [MAX_ENTRIES];
    token_t           inject;
    entry_wr_t        wr;
    logic [CNT_W-1:0] count;

    ipil_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .family        (family),
        .address_high  (address_high),
        .address_low   (address_low),
        .has_prefix    (has_prefix),
        .prefix_length (prefix_length),
        .tail          (chain[MAX_ENTRIES-1]),
        .inject        (inject),
        .wr            (wr),
        .count         (count),
        .strobe        (strobe),
        .status        (status)
    );

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        token_t tok_in;
        if (i == 0)
        begin : g_head
            assign tok_in = inject;
        end
        else
        begin : g_link
            assign tok_in = chain[i-1];
        end

        ipil_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (count > CNT_W'(i)),
            .we      (wr.en && (count == CNT_W'(i))),
            .wr      (wr),
            .tok_in  (tok_in),
            .tok_out (chain[i])
        );
    end

endmodule
